// ----- hw/rtl/spq_pkg.sv -----
// Package: shared types, operation and status codes for the sorted priority queue.
`default_nettype none

package spq_pkg;

    localparam int CAPACITY_DEF      = 16;
    localparam int PRIORITY_BITS_DEF = 16;

    localparam logic [1:0] OP_ENQUEUE = 2'd0;
    localparam logic [1:0] OP_DEQUEUE = 2'd1;
    localparam logic [1:0] OP_PEEK    = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] value;
        logic [15:0]        priority_req;
    } spq_req_t;

    typedef struct packed {
        logic signed [31:0] value_out;
        logic [1:0]         status;
        logic [4:0]         count;
    } spq_rsp_t;

    typedef struct packed {
        logic enq;
        logic deq;
    } spq_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/spq_cell.sv -----
// One queue slot: holds a value and priority, shifts right on insert, left on removal.
`default_nettype none

module spq_cell
    import spq_pkg::*;
#(
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
    input  wire                       clk,
    input  wire spq_cmd_t             cmd,
    input  wire                       occ,
    input  wire                       left_keep,
    input  wire  [31:0]               new_value,
    input  wire  [PRIORITY_BITS-1:0]  new_prio,
    input  wire  [31:0]               left_value,
    input  wire  [PRIORITY_BITS-1:0]  left_prio,
    input  wire  [31:0]               right_value,
    input  wire  [PRIORITY_BITS-1:0]  right_prio,
    output logic                      keep,
    output logic [31:0]               value,
    output logic [PRIORITY_BITS-1:0]  prio
);

    logic [31:0]              value_reg;
    logic [31:0]              value_next;
    logic [PRIORITY_BITS-1:0] prio_reg;
    logic [PRIORITY_BITS-1:0] prio_next;

    // ties stay ahead of the newcomer: first come, first served
    assign keep  = occ && (prio_reg <= new_prio);
    assign value = value_reg;
    assign prio  = prio_reg;

    always_comb
    begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (cmd.enq && !keep)
        begin
            if (left_keep)
            begin
                value_next = new_value;
                prio_next  = new_prio;
            end
            else
            begin
                value_next = left_value;
                prio_next  = left_prio;
            end
        end
        else if (cmd.deq)
        begin
            value_next = right_value;
            prio_next  = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_priority_queue_core.sv -----
// Sorted priority queue: min-first, FIFO among equal priorities, held in a row of slot cells.
//
// Usage:
//   req channel (req_valid/req_ready/req) carries one operation per transaction:
//   enqueue, dequeue, peek or clear. rsp channel (rsp_valid/rsp_ready/rsp) returns
//   exactly one response per request with the front value, a status and the count.
//   Latency: the response is registered and appears the cycle after acceptance.
//   Throughput: one transaction per cycle while rsp is not stalled. Every slot compares
//   its priority with the incoming one in parallel and shifts by one position, so an
//   insert or removal completes in the accepting cycle.
//   Stall: while rsp holds an unaccepted response, req_ready follows rsp_ready; a
//   new request is accepted in the same cycle the pending response leaves.
//   Reset: rsp_valid and the entry count clear; slot contents stay undefined and
//   are never read until written.
//   Full queue: enqueue is dropped with a full status. Empty queue: dequeue and
//   peek give an empty status and value 0.
`default_nettype none

module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
    input  wire           clk,
    input  wire           rst_n,
    input  wire           req_valid,
    output logic          req_ready,
    input  wire spq_req_t req,
    output logic          rsp_valid,
    input  wire           rsp_ready,
    output spq_rsp_t      rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    spq_rsp_t                 rsp_reg;
    spq_rsp_t                 rsp_next;

    logic                     accept;
    logic                     empty;
    logic                     full;
    logic [PRIORITY_BITS-1:0] new_prio;
    spq_cmd_t                 cmd;

    logic [CAPACITY-1:0]      occ;
    logic [CAPACITY-1:0]      keep;
    logic [31:0]              cell_value [CAPACITY];
    logic [PRIORITY_BITS-1:0] cell_prio  [CAPACITY];

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign new_prio  = PRIORITY_BITS'(req.priority_req);

    assign cmd.enq = accept && (req.op == OP_ENQUEUE) && !full;
    assign cmd.deq = accept && (req.op == OP_DEQUEUE) && !empty;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic                     left_keep;
            logic [31:0]              left_value;
            logic [PRIORITY_BITS-1:0] left_prio;
            logic [31:0]              right_value;
            logic [PRIORITY_BITS-1:0] right_prio;

            assign occ[g] = (CNT_W'(g) < count_reg);

            if (g == 0)
            begin : g_first
                assign left_keep  = 1'b1;
                assign left_value = req.value;
                assign left_prio  = new_prio;
            end
            else
            begin : g_mid
                assign left_keep  = keep[g-1];
                assign left_value = cell_value[g-1];
                assign left_prio  = cell_prio[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign right_value = cell_value[g];
                assign right_prio  = cell_prio[g];
            end
            else
            begin : g_inner
                assign right_value = cell_value[g+1];
                assign right_prio  = cell_prio[g+1];
            end

            spq_cell #(
                .PRIORITY_BITS(PRIORITY_BITS)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .occ        (occ[g]),
                .left_keep  (left_keep),
                .new_value  (req.value),
                .new_prio   (new_prio),
                .left_value (left_value),
                .left_prio  (left_prio),
                .right_value(right_value),
                .right_prio (right_prio),
                .keep       (keep[g]),
                .value      (cell_value[g]),
                .prio       (cell_prio[g])
            );
        end
    endgenerate

    always_comb
    begin
        count_next          = count_reg;
        rsp_next            = rsp_reg;
        rsp_valid_next      = rsp_valid_reg;
        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (accept)
        begin
            rsp_valid_next     = 1'b1;
            rsp_next.value_out = '0;
            rsp_next.status    = ST_OK;
            case (req.op)
                OP_ENQUEUE:
                begin
                    if (full)
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_DEQUEUE:
                begin
                    if (empty)
                    begin
                        rsp_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        rsp_next.value_out = cell_value[0];
                        count_next         = count_reg - 1'b1;
                    end
                end
                OP_PEEK:
                begin
                    if (empty)
                    begin
                        rsp_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        rsp_next.value_out = cell_value[0];
                    end
                end
                default:
                begin
                    count_next = '0;
                end
            endcase
            rsp_next.count = 5'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Testbench for sorted_priority_queue_core: directed table plus random traffic, checked by a model.
`timescale 1ns / 1ps

module testbench;
    import spq_pkg::*;

    localparam int CAP            = CAPACITY_DEF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 1800;

    typedef enum int { MODE_FILL, MODE_DRAIN, MODE_MIXED } traffic_mode_t;

    typedef struct {
        spq_req_t req;
        bit       typed;
        spq_rsp_t rsp;
    } stim_row_t;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    spq_req_t req;
    logic     rsp_valid;
    logic     rsp_ready;
    spq_rsp_t rsp;

    sorted_priority_queue_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    logic signed [31:0] model_values [CAP];
    logic [15:0]        model_prios [CAP];
    int                 model_count;

    spq_rsp_t  expected_rsps [$];
    stim_row_t directed_rows [$];

    int  error_count;
    int  idle_cycles;
    int  op_counts [4];
    int  ok_seen;
    int  empty_seen;
    int  full_seen;
    int  max_count_seen;
    bit  tx_quiet;
    bit  rx_quiet;

    always #10 clk = ~clk;

    // Sorted-array model: min priority first, FIFO among ties.
    function automatic spq_rsp_t queue_model_apply(spq_req_t r);
        spq_rsp_t res;
        int       pos;
        res = '0;
        case (r.op)
            OP_ENQUEUE: begin
                if (model_count >= CAP) begin
                    res.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < model_count && model_prios[pos] <= r.priority_req)
                        pos++;
                    for (int i = model_count; i > pos; i--) begin
                        model_values[i] = model_values[i - 1];
                        model_prios[i]  = model_prios[i - 1];
                    end
                    model_values[pos] = r.value;
                    model_prios[pos]  = r.priority_req;
                    model_count++;
                    res.status = ST_OK;
                end
            end
            OP_DEQUEUE: begin
                if (model_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.value_out = model_values[0];
                    for (int i = 1; i < model_count; i++) begin
                        model_values[i - 1] = model_values[i];
                        model_prios[i - 1]  = model_prios[i];
                    end
                    model_count--;
                    res.status = ST_OK;
                end
            end
            OP_PEEK: begin
                if (model_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.value_out = model_values[0];
                    res.status    = ST_OK;
                end
            end
            default: begin
                model_count = 0;
                res.status  = ST_OK;
            end
        endcase
        res.count = 5'(model_count);
        return res;
    endfunction

    function automatic spq_req_t make_req(logic [1:0] op, logic [31:0] val, logic [15:0] pr);
        spq_req_t r;
        r.op           = op;
        r.value        = val;
        r.priority_req = pr;
        return r;
    endfunction

    function automatic spq_rsp_t make_rsp(logic [31:0] val, logic [1:0] st, int cnt);
        spq_rsp_t r;
        r.value_out = val;
        r.status    = st;
        r.count     = 5'(cnt);
        return r;
    endfunction

    task automatic add_row(spq_req_t r, bit typed, spq_rsp_t e);
        stim_row_t row;
        row.req   = r;
        row.typed = typed;
        row.rsp   = e;
        directed_rows.push_back(row);
    endtask

    function automatic int idle_len();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return $urandom_range(2, 1);
        else if (sel < 95)
            return $urandom_range(8, 3);
        return $urandom_range(60, 20);
    endfunction

    function automatic spq_req_t random_req(traffic_mode_t mode);
        spq_req_t r;
        int       sel;
        int       enq_w;
        int       deq_w;
        int       peek_w;
        case (mode)
            MODE_FILL:  begin enq_w = 75; deq_w = 12; peek_w = 12; end
            MODE_DRAIN: begin enq_w = 15; deq_w = 65; peek_w = 18; end
            default:    begin enq_w = 45; deq_w = 35; peek_w = 18; end
        endcase
        sel = $urandom_range(99);
        if (sel < enq_w)
            r.op = OP_ENQUEUE;
        else if (sel < enq_w + deq_w)
            r.op = OP_DEQUEUE;
        else if (sel < enq_w + deq_w + peek_w)
            r.op = OP_PEEK;
        else
            r.op = OP_CLEAR;
        sel = $urandom_range(99);
        if (sel < 3)
            r.value = 32'h8000_0000;
        else if (sel < 6)
            r.value = 32'h7FFF_FFFF;
        else
            r.value = $urandom;
        sel = $urandom_range(99);
        if (sel < 30)
            r.priority_req = 16'($urandom_range(3));
        else if (sel < 35)
            r.priority_req = 16'h0000;
        else if (sel < 40)
            r.priority_req = 16'hFFFF;
        else
            r.priority_req = 16'($urandom);
        return r;
    endfunction

    task automatic send_req(spq_req_t r, bit typed, spq_rsp_t typed_rsp);
        int       gap;
        spq_rsp_t pred;
        if ($urandom_range(79) == 0)
            tx_quiet = ~tx_quiet;
        gap = (tx_quiet || $urandom_range(99) < 50) ? 0 : idle_len();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (!req_ready);
        pred = queue_model_apply(r);
        op_counts[r.op]++;
        expected_rsps.push_back(typed ? typed_rsp : pred);
    endtask

    task automatic drain_wait();
        req_valid <= 1'b0;
        while (expected_rsps.size() > 0)
            @(posedge clk);
    endtask

    task automatic check_rsp(spq_rsp_t got);
        spq_rsp_t exp;
        if (expected_rsps.size() == 0) begin
            $error("unexpected response: value_out %h status %0d count %0d",
                   got.value_out, got.status, got.count);
            error_count++;
        end else begin
            exp = expected_rsps.pop_front();
            if (got.value_out !== exp.value_out) begin
                $error("value_out mismatch: expected %h, actual %h", exp.value_out, got.value_out);
                error_count++;
            end
            if (got.status !== exp.status) begin
                $error("status mismatch: expected %0d, actual %0d", exp.status, got.status);
                error_count++;
            end
            if (got.count !== exp.count) begin
                $error("count mismatch: expected %0d, actual %0d", exp.count, got.count);
                error_count++;
            end
        end
        case (got.status)
            ST_OK:    ok_seen++;
            ST_EMPTY: empty_seen++;
            ST_FULL:  full_seen++;
            default:  ;
        endcase
        if (got.count > max_count_seen)
            max_count_seen = got.count;
    endtask

    // Response side: random backpressure with quiet stretches.
    initial begin
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
                check_rsp(rsp);
            if ($urandom_range(199) == 0)
                rx_quiet = ~rx_quiet;
            if (stall_left == 0 && !rx_quiet && $urandom_range(99) < 25)
                stall_left = idle_len();
            if (stall_left > 0) begin
                rsp_ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        traffic_mode_t mode;
        int            mode_left;
        spq_rsp_t      none;
        clk            = 1'b0;
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req            = '0;
        rsp_ready      = 1'b0;
        error_count    = 0;
        idle_cycles    = 0;
        ok_seen        = 0;
        empty_seen     = 0;
        full_seen      = 0;
        max_count_seen = 0;
        tx_quiet       = 1'b0;
        rx_quiet       = 1'b0;
        model_count    = 0;
        none           = '0;
        foreach (op_counts[i]) op_counts[i] = 0;

        // empty errors, extremes, tie ordering, fill to full, full error, clear
        add_row(make_req(OP_PEEK, 32'hFFFF_FFFF, 16'hFFFF), 1, make_rsp(0, ST_EMPTY, 0));
        add_row(make_req(OP_DEQUEUE, 32'hFFFF_FFFF, 16'h0000), 1, make_rsp(0, ST_EMPTY, 0));
        add_row(make_req(OP_ENQUEUE, 32'h7FFF_FFFF, 16'hFFFF), 1, make_rsp(0, ST_OK, 1));
        add_row(make_req(OP_ENQUEUE, 32'h8000_0000, 16'h0000), 1, make_rsp(0, ST_OK, 2));
        add_row(make_req(OP_ENQUEUE, 32'hFFFF_FFFF, 16'h0000), 1, make_rsp(0, ST_OK, 3));
        add_row(make_req(OP_PEEK, 32'h0, 16'h0), 1, make_rsp(32'h8000_0000, ST_OK, 3));
        add_row(make_req(OP_DEQUEUE, 32'h0, 16'h0), 1, make_rsp(32'h8000_0000, ST_OK, 2));
        for (int i = 0; i < CAP - 2; i++)
            add_row(make_req(OP_ENQUEUE, 32'h1000_0000 + i,
                             (i % 3 == 0) ? 16'hFFFF : 16'(i * 16'h1111)),
                    1, make_rsp(0, ST_OK, i + 3));
        add_row(make_req(OP_ENQUEUE, 32'h5555_5555, 16'h0001), 1, make_rsp(0, ST_FULL, CAP));
        add_row(make_req(OP_PEEK, 32'h0, 16'h0), 0, none);
        add_row(make_req(OP_CLEAR, 32'hAAAA_AAAA, 16'h5555), 1, make_rsp(0, ST_OK, 0));
        add_row(make_req(OP_PEEK, 32'h0, 16'h0), 1, make_rsp(0, ST_EMPTY, 0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
        drain_wait();

        mode      = MODE_FILL;
        mode_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (mode_left == 0) begin
                mode      = traffic_mode_t'($urandom_range(2));
                mode_left = $urandom_range(60, 10);
            end
            mode_left--;
            if (n == RANDOM_ITEMS / 2)
                drain_wait();
            send_req(random_req(mode), 0, none);
        end
        req_valid <= 1'b0;

        while (expected_rsps.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Covered %0d enqueue, %0d dequeue, %0d peek, %0d clear transactions",
                 op_counts[OP_ENQUEUE], op_counts[OP_DEQUEUE], op_counts[OP_PEEK],
                 op_counts[OP_CLEAR]);
        $display("Responses: %0d ok, %0d empty, %0d full; highest count %0d",
                 ok_seen, empty_seen, full_seen, max_count_seen);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
